// ===== rtl/core/crlf_pkg.sv =====
// shared types and constants of the crlf line framer
package crlf_pkg;

    localparam int LIMIT_W = 13;
    localparam logic [LIMIT_W-1:0] LIMIT_MIN   = 13'd4;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX   = 13'd4096;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd512;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_LINE_LIMIT = 1'b0;

    typedef struct packed {
        logic [7:0] data;
        logic       line_end;
        logic       cut;
    } crlf_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } crlf_qstat_t;

endpackage

// ===== rtl/core/crlf_line_framer_with_truncation.sv =====
// top level of the crlf line framer: config register and front/queue/back
//
// Byte stream in on in_valid/in_ready/in_byte, one word per byte. Lines end
// with cr lf; every byte of a line comes out on out_valid/out_ready with the
// closing lf marked by line_end. A line that reaches line_limit-1 bytes
// without cr lf is cut: cr and lf are inserted with was_cut set (line_end on
// the lf) and the rest of the line up to the next cr lf is dropped.
// line_limit sits at apb addresses 0..3, reset 512, clamped to 4..4096 on use;
// write it only while the block is idle.
// An accepted byte passes through the queue and then the output register.
// Throughput: one byte per cycle while the queue has room; the front
// classifies each byte as it is taken and a four-word queue feeds the back,
// which puts out one word per cycle while the receiver takes them, so a cut
// takes two output words and the queue absorbs the extra word. When the
// receiver stalls, the output word holds and the queue fills; in_ready drops
// once the queue is full. Dropped bytes take no queue space but are still only
// accepted while the queue has room. Reset clears line state, the queue and the
// output register and loads the default limit.
module crlf_line_framer_with_truncation
    import crlf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic              line_end,
    output logic              was_cut,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [LIMIT_W-1:0] line_limit_reg;
    logic               reg_sel;
    logic               push;
    logic               pop;
    crlf_entry_t        push_entry;
    crlf_entry_t        head;
    crlf_qstat_t        qstat;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[ADDR_W-1] == REG_LINE_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            line_limit_reg <= LIMIT_RESET;
        else if (psel && penable && pwrite && reg_sel)
            line_limit_reg <= pwdata[LIMIT_W-1:0];
    end

    assign prdata = reg_sel ? {{(DATA_W-LIMIT_W){1'b0}}, line_limit_reg} : '0;

    crlf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .line_limit (line_limit_reg),
        .qstat      (qstat),
        .push       (push),
        .push_entry (push_entry)
    );

    crlf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .qstat      (qstat)
    );

    crlf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .qstat     (qstat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .line_end  (line_end),
        .was_cut   (was_cut)
    );

endmodule

// ===== rtl/core/crlf_front.sv =====
// front end: takes bytes, tracks line state, decides pass, cut or drop
module crlf_front
    import crlf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         in_byte,
    input  logic [LIMIT_W-1:0] line_limit,
    input  crlf_qstat_t        qstat,
    output logic               push,
    output crlf_entry_t        push_entry
);

    logic               prev_cr_reg, prev_cr_next;
    logic               dropping_reg, dropping_next;
    logic [LIMIT_W-1:0] count_reg, count_next;
    logic [LIMIT_W-1:0] eff_limit;
    logic               accept;
    logic               closes;
    logic               is_cr;
    logic               at_limit;

    always_comb
    begin
        if (line_limit < LIMIT_MIN)
            eff_limit = LIMIT_MIN;
        else if (line_limit > LIMIT_MAX)
            eff_limit = LIMIT_MAX;
        else
            eff_limit = line_limit;
    end

    assign in_ready = !qstat.full;
    assign accept   = in_valid && in_ready;
    assign is_cr    = (in_byte == CHAR_CR);
    assign closes   = prev_cr_reg && (in_byte == CHAR_LF);
    // cut when count + 1 reaches limit - 1
    assign at_limit = ({1'b0, count_reg} + (LIMIT_W+1)'(2)) >= {1'b0, eff_limit};

    always_comb
    begin
        prev_cr_next        = prev_cr_reg;
        dropping_next       = dropping_reg;
        count_next          = count_reg;
        push                = 1'b0;
        push_entry.data     = in_byte;
        push_entry.line_end = 1'b0;
        push_entry.cut      = 1'b0;
        if (accept)
        begin
            if (dropping_reg)
            begin
                count_next   = '0;
                prev_cr_next = closes ? 1'b0 : is_cr;
                if (closes)
                    dropping_next = 1'b0;
            end
            else if (closes)
            begin
                push                = 1'b1;
                push_entry.line_end = 1'b1;
                prev_cr_next        = 1'b0;
                count_next          = '0;
            end
            else if (at_limit)
            begin
                push            = 1'b1;
                push_entry.data = '0;
                push_entry.cut  = 1'b1;
                dropping_next   = 1'b1;
                prev_cr_next    = is_cr;
                count_next      = '0;
            end
            else
            begin
                push         = 1'b1;
                count_next   = count_reg + LIMIT_W'(1);
                prev_cr_next = is_cr;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_cr_reg  <= 1'b0;
            dropping_reg <= 1'b0;
            count_reg    <= '0;
        end
        else
        begin
            prev_cr_reg  <= prev_cr_next;
            dropping_reg <= dropping_next;
            count_reg    <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < LIMIT_MAX)
        else $error("line count ran past the largest limit");

    a_drop_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        dropping_reg |-> count_reg == '0)
        else $error("line count moved while dropping a tail");

    a_no_push_drop: assert property (@(posedge clk) disable iff (!rst_n)
        dropping_reg && !(prev_cr_reg && in_byte == CHAR_LF) |-> !push)
        else $error("word queued while dropping a tail");

endmodule

// ===== rtl/core/crlf_queue.sv =====
// short queue of classified words between front and back
module crlf_queue
    import crlf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  crlf_entry_t push_entry,
    input  logic        pop,
    output crlf_entry_t head,
    output crlf_qstat_t qstat
);

    crlf_entry_t         mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;

    assign qstat.full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign head        = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            if (push && !pop)
                count_reg <= count_reg + (QUEUE_AW+1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (QUEUE_AW+1)'(1);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && qstat.full))
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && qstat.empty))
        else $error("pop from an empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

// ===== rtl/core/crlf_back.sv =====
// back end: expands queued words into output words behind an output register
module crlf_back
    import crlf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  crlf_entry_t head,
    input  crlf_qstat_t qstat,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        line_end,
    output logic        was_cut
);

    typedef enum logic {EMIT_WORD, EMIT_LF} state_t;

    state_t     state_reg, state_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       end_reg, end_next;
    logic       cut_reg, cut_next;
    logic       load;

    assign load = !valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        end_next   = end_reg;
        cut_next   = cut_reg;
        pop        = 1'b0;
        if (load)
        begin
            valid_next = !qstat.empty;
            if (!qstat.empty)
            begin
                case (state_reg)
                    EMIT_WORD:
                    begin
                        if (head.cut)
                        begin
                            // first word of a cut: inserted cr, entry stays
                            byte_next  = CHAR_CR;
                            end_next   = 1'b0;
                            cut_next   = 1'b1;
                            state_next = EMIT_LF;
                        end
                        else
                        begin
                            byte_next = head.data;
                            end_next  = head.line_end;
                            cut_next  = 1'b0;
                            pop       = 1'b1;
                        end
                    end
                    EMIT_LF:
                    begin
                        byte_next  = CHAR_LF;
                        end_next   = 1'b1;
                        cut_next   = 1'b1;
                        pop        = 1'b1;
                        state_next = EMIT_WORD;
                    end
                    default:
                    begin
                        state_next = EMIT_WORD;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= EMIT_WORD;
            valid_reg <= 1'b0;
            byte_reg  <= '0;
            end_reg   <= 1'b0;
            cut_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            byte_reg  <= byte_next;
            end_reg   <= end_next;
            cut_reg   <= cut_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign line_end  = end_reg;
    assign was_cut   = cut_reg;

    a_lf_follows_cr: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && out_ready && cut_reg && !end_reg
        |=> valid_reg && cut_reg && end_reg && byte_reg == CHAR_LF)
        else $error("cut cr not followed by cut lf");

    a_lf_state: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == EMIT_LF |-> valid_reg && cut_reg && !end_reg && !qstat.empty)
        else $error("pending cut lf without its cr on the output");

    a_cut_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && cut_reg |-> byte_reg == CHAR_CR || byte_reg == CHAR_LF)
        else $error("cut word carries a byte other than cr or lf");

endmodule
